### rtl/pulse_period_speed_meter_unit_assert.svh
// Assertion macros for the pulse period speed meter checker.
// No dependencies; include by bare file name.
`ifndef PULSE_PERIOD_SPEED_METER_UNIT_ASSERT_SVH
`define PULSE_PERIOD_SPEED_METER_UNIT_ASSERT_SVH

// Check a property while out of reset.
`define PPSM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PPSM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ppsm_pkg.sv
// Shared constants for the pulse period speed meter.
// No dependencies.
package ppsm_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int SPEED_WIDTH     = 32;
  localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = 32'd600000;

endpackage

### rtl/pulse_period_speed_meter_unit.sv
// Bit-serial restoring divider, one quotient bit per cycle while in ST_RUN.
// A new input beat is taken only in ST_IDLE, once the previous division is done.
// A result waiting on the output register holds the divider in ST_WAIT and delays the next input.
// Reset (synchronous, rst_n low): speed constant 600000, previous capture 0,
// no result pending.
// Depends on ppsm_pkg.
module pulse_period_speed_meter_unit
  import ppsm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SPEED_WIDTH-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COUNT_WIDTH-1:0] in_captured_count,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SPEED_WIDTH-1:0] out_speed_value,
  output logic [COUNT_WIDTH:0]   out_period_ticks
);

  localparam int PW    = COUNT_WIDTH + 1;
  localparam int CNT_W = $clog2(SPEED_WIDTH);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} state_t;

  state_t                 state_r, state_nxt;
  logic [SPEED_WIDTH-1:0] speed_r, speed_nxt;
  logic [COUNT_WIDTH-1:0] prev_r, prev_nxt;
  logic [PW-1:0]          div_r, div_nxt;
  logic [PW-1:0]          rem_r, rem_nxt;
  logic [SPEED_WIDTH-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SPEED_WIDTH-1:0] out_speed_r, out_speed_nxt;
  logic [PW-1:0]          out_per_r, out_per_nxt;

  logic [COUNT_WIDTH-1:0] diff;
  logic [PW-1:0]          period;
  logic [PW:0]            rem_sh;
  logic                   ge;
  logic [SPEED_WIDTH-1:0] quo_step;
  logic [PW-1:0]          rem_step;
  logic                   out_free;

  assign cfg_ready        = 1'b1;
  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_speed_value  = out_speed_r;
  assign out_period_ticks = out_per_r;

  assign diff   = in_captured_count - prev_r;
  assign period = (diff == '0) ? {1'b1, {COUNT_WIDTH{1'b0}}} : {1'b0, diff};

  assign rem_sh   = {rem_r, quo_r[SPEED_WIDTH-1]};
  assign ge       = (rem_sh >= {1'b0, div_r});
  assign rem_step = ge ? PW'(rem_sh - {1'b0, div_r}) : rem_sh[PW-1:0];
  assign quo_step = {quo_r[SPEED_WIDTH-2:0], ge};
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    speed_nxt     = speed_r;
    prev_nxt      = prev_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_speed_nxt = out_speed_r;
    out_per_nxt   = out_per_r;

    if (cfg_valid && cfg_ready) begin
      speed_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          prev_nxt  = in_captured_count;
          div_nxt   = period;
          rem_nxt   = '0;
          quo_nxt   = speed_r;
          cnt_nxt   = CNT_W'(SPEED_WIDTH - 1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_speed_nxt = quo_step;
            out_per_nxt   = div_r;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = quo_r;
          out_per_nxt   = div_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    out_speed_r <= out_speed_nxt;
    out_per_r   <= out_per_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      speed_r     <= SPEED_RESET;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      speed_r     <= speed_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/ppsm_checker.sv
// Port-level checks for the pulse period speed meter, bound to pulse_period_speed_meter_unit.
// Depends on ppsm_pkg and pulse_period_speed_meter_unit_assert.svh.
`include "pulse_period_speed_meter_unit_assert.svh"

module ppsm_checker
  import ppsm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SPEED_WIDTH-1:0] out_speed_value,
  input logic [COUNT_WIDTH:0]   out_period_ticks
);

  `PPSM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out beat dropped")
  `PPSM_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_speed_value) && $stable(out_period_ticks), "out payload moved")
  `PPSM_ASSERT(a_period_nonzero, clk, rst_n, out_valid |-> out_period_ticks != '0, "zero period")
  `PPSM_ASSERT(a_busy_after_in, clk, rst_n, in_valid && in_ready |=> !in_ready, "input taken while dividing")
  `PPSM_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind pulse_period_speed_meter_unit ppsm_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_ppsm_checker (.*);
